// ===== src/bre_pkg.sv =====
package bre_pkg;

	// fixed field and datapath widths
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 31;
	localparam int STATE_W   = 8;
	localparam int CFG_IDX_W = 1;
	localparam int SECS_W    = 12;
	localparam int PROD_W    = SECS_W + CAP_W;
	localparam int DVS_W     = 32;

	// op codes
	localparam logic OP_READING = 1'b0;
	localparam logic OP_REPORT  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_FULL  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DESIGN_CAP = 1'b1;

	// result status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	// arithmetic constants
	localparam logic [SECS_W-1:0]        SECS_PER_HOUR = 12'd3600;
	localparam logic signed [DATA_W-1:0] TIME_UNKNOWN  = -32'sd1;
	localparam logic signed [DATA_W-1:0] INT32_MAX_C   = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] INT32_MIN_C   = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] LFC_RESET     = -32'sd1;

	typedef struct packed {
		logic                     op;
		logic [STATE_W-1:0]       battery_state;
		logic signed [DATA_W-1:0] rate_in;
		logic signed [DATA_W-1:0] capacity_in;
	} in_item_t;

	typedef struct packed {
		logic                     status;
		logic [STATE_W-1:0]       state_out;
		logic signed [DATA_W-1:0] rate_out;
		logic [CAP_W-1:0]         capacity_out;
		logic signed [DATA_W-1:0] full_cap_out;
		logic signed [DATA_W-1:0] secs_left;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_SUM,
		ST_DIV_MEAN,
		ST_MUL,
		ST_DIV_TIME,
		ST_DONE
	} state_t;

endpackage

// ===== src/bre_ram.sv =====
module bre_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/battery_runtime_estimator.sv =====
// Battery runtime estimator. A reading (op 0) is checked for a negative
// capacity or one above the last-full-charge register and, unless rejected,
// cached; its result beat is valid from the edge after acceptance. A report
// (op 1) pushes the cached rate into a ring of the last RATE_DEPTH rates,
// sums the filled entries one per cycle from a small RAM, and then runs two
// divisions, the mean rate and 3600 * capacity / mean, on one restoring
// divider that yields one quotient bit per cycle. The sum is SUM_W = 32 +
// clog2(RATE_DEPTH + 1) bits wide and the product PROD_W = 43 bits wide.
// When the cached rate is not positive the divisions are skipped; a zero
// mean skips only the second division. One item is in flight at a time,
// and a new item is taken only when the output register is empty or its beat
// leaves in the same cycle, so a stalled result holds off the input.
module battery_runtime_estimator #(
	parameter int RATE_DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  bre_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output bre_pkg::out_item_t                  out_data,
	input  logic                                cfg_we,
	input  logic [bre_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bre_pkg::DATA_W-1:0]          cfg_data
);

	localparam int ADDR_W = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(RATE_DEPTH + 1);
	localparam int SUM_W  = bre_pkg::DATA_W + CNT_W;
	localparam int DVD_W  = (SUM_W > bre_pkg::PROD_W) ? SUM_W : bre_pkg::PROD_W;
	localparam int STEP_W = $clog2(DVD_W + 1);
	localparam int DVS_W  = bre_pkg::DVS_W;
	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(RATE_DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(RATE_DEPTH);

	bre_pkg::state_t state_q, state_nx;

	// configuration registers
	logic signed [bre_pkg::DATA_W-1:0] lfc_q;
	logic [bre_pkg::CAP_W-1:0]         dcap_q;

	// cached reading
	logic [bre_pkg::STATE_W-1:0]       cached_state_q;
	logic signed [bre_pkg::DATA_W-1:0] cached_rate_q;
	logic [bre_pkg::CAP_W-1:0]         cached_cap_q;

	// ring bookkeeping and sum
	logic [ADDR_W-1:0]       slot_q;
	logic [CNT_W-1:0]        fill_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    pend_q;
	logic signed [SUM_W-1:0] acc_q;

	// shared divider
	logic [DVD_W-1:0]  dq_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              mean_neg_q;
	logic              unknown_q;

	// output register
	logic               out_valid_q;
	bre_pkg::out_item_t out_q;

	// control decodes
	logic in_accept;
	logic out_free;
	logic ram_we;
	logic sum_issue;
	logic sum_done;
	logic div_last;

	logic signed [bre_pkg::DATA_W-1:0] rd_data;
	logic [SUM_W-1:0]                  acc_mag;
	logic [DVS_W:0]                    trial;
	logic [DVS_W:0]                    diff;
	logic                              q_bit;
	logic [DVS_W-1:0]                  rem_nx;
	logic [bre_pkg::PROD_W-1:0]        prod;
	logic [bre_pkg::PROD_W-1:0]        quot;
	logic signed [bre_pkg::DATA_W-1:0] full_cap;
	logic signed [bre_pkg::DATA_W-1:0] time_val;
	logic                              reject;
	bre_pkg::out_item_t                read_res;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// rate ring
	bre_ram #(
		.WIDTH (bre_pkg::DATA_W),
		.DEPTH (RATE_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (cached_rate_q),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			bre_pkg::ST_IDLE: begin
				if (in_accept && in_data.op == bre_pkg::OP_REPORT) begin
					state_nx = bre_pkg::ST_PUSH;
				end
			end
			bre_pkg::ST_PUSH: begin
				state_nx = (cached_rate_q > 0) ? bre_pkg::ST_SUM : bre_pkg::ST_DONE;
			end
			bre_pkg::ST_SUM: begin
				if (sum_done) begin
					state_nx = bre_pkg::ST_DIV_MEAN;
				end
			end
			bre_pkg::ST_DIV_MEAN: begin
				if (div_last) begin
					state_nx = bre_pkg::ST_MUL;
				end
			end
			bre_pkg::ST_MUL: begin
				state_nx = (dq_q[DVS_W-1:0] == '0) ? bre_pkg::ST_DONE : bre_pkg::ST_DIV_TIME;
			end
			bre_pkg::ST_DIV_TIME: begin
				if (div_last) begin
					state_nx = bre_pkg::ST_DONE;
				end
			end
			bre_pkg::ST_DONE: begin
				if (out_free) begin
					state_nx = bre_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = bre_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		sum_issue = 1'b0;
		sum_done  = 1'b0;
		div_last  = 1'b0;
		case (state_q)
			bre_pkg::ST_IDLE: begin
				in_stall = !out_free;
			end
			bre_pkg::ST_PUSH: begin
				ram_we = 1'b1;
			end
			bre_pkg::ST_SUM: begin
				sum_issue = (idx_q != fill_q);
				sum_done  = (idx_q == fill_q) && !pend_q;
			end
			bre_pkg::ST_DIV_MEAN, bre_pkg::ST_DIV_TIME: begin
				div_last = (step_q == STEP_W'(1));
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// divider step: one quotient bit per cycle
	always_comb begin
		trial  = {rem_q, dq_q[DVD_W-1]};
		diff   = trial - {1'b0, dvs_q};
		q_bit  = (trial >= {1'b0, dvs_q});
		rem_nx = q_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
	end

	// sum magnitude, product, quotient, full capacity and reading result
	always_comb begin
		acc_mag  = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
		prod     = bre_pkg::PROD_W'(bre_pkg::SECS_PER_HOUR) * bre_pkg::PROD_W'(cached_cap_q);
		quot     = dq_q[bre_pkg::PROD_W-1:0];
		full_cap = (lfc_q < 0) ? bre_pkg::DATA_W'(dcap_q) : lfc_q;
		reject   = (in_data.capacity_in < 0) ||
			((lfc_q > 0) && (in_data.capacity_in > lfc_q));
		read_res        = '0;
		read_res.status = reject ? bre_pkg::STATUS_BAD : bre_pkg::STATUS_OK;
	end

	// saturate the signed time estimate
	always_comb begin
		if (unknown_q) begin
			time_val = bre_pkg::TIME_UNKNOWN;
		end else if (!mean_neg_q) begin
			if (quot > bre_pkg::PROD_W'(bre_pkg::INT32_MAX_C)) begin
				time_val = bre_pkg::INT32_MAX_C;
			end else begin
				time_val = quot[bre_pkg::DATA_W-1:0];
			end
		end else begin
			if (quot > bre_pkg::PROD_W'(33'h1_0000_0000 >> 1)) begin
				time_val = bre_pkg::INT32_MIN_C;
			end else begin
				time_val = -quot[bre_pkg::DATA_W-1:0];
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bre_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfc_q  <= bre_pkg::LFC_RESET;
			dcap_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == bre_pkg::CFG_LAST_FULL) begin
				lfc_q <= cfg_data;
			end else if (cfg_index == bre_pkg::CFG_DESIGN_CAP) begin
				dcap_q <= cfg_data[bre_pkg::CAP_W-1:0];
			end
		end
	end

	// reading cache
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cached_state_q <= '0;
			cached_rate_q  <= '0;
			cached_cap_q   <= '0;
		end else if (in_accept && in_data.op == bre_pkg::OP_READING && !reject) begin
			cached_state_q <= in_data.battery_state;
			cached_rate_q  <= in_data.rate_in;
			cached_cap_q   <= in_data.capacity_in[bre_pkg::CAP_W-1:0];
		end
	end

	// ring write slot and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (ram_we) begin
			slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + ADDR_W'(1);
			if (fill_q != FULL_CNT) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	// ring sum, one entry per cycle behind the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pend_q <= 1'b0;
			acc_q  <= '0;
		end else if (state_q == bre_pkg::ST_PUSH) begin
			idx_q  <= '0;
			pend_q <= 1'b0;
			acc_q  <= '0;
		end else if (state_q == bre_pkg::ST_SUM) begin
			pend_q <= sum_issue;
			if (sum_issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (pend_q) begin
				acc_q <= acc_q + SUM_W'(rd_data);
			end
		end
	end

	// shared divider and estimate flags
	always_ff @(posedge clk) begin
		case (state_q)
			bre_pkg::ST_PUSH: begin
				unknown_q  <= !(cached_rate_q > 0);
				mean_neg_q <= 1'b0;
			end
			bre_pkg::ST_SUM: begin
				if (sum_done) begin
					dq_q       <= DVD_W'(acc_mag) << (DVD_W - SUM_W);
					rem_q      <= '0;
					dvs_q      <= DVS_W'(fill_q);
					step_q     <= STEP_W'(SUM_W);
					mean_neg_q <= acc_q[SUM_W-1];
				end
			end
			bre_pkg::ST_DIV_MEAN, bre_pkg::ST_DIV_TIME: begin
				dq_q   <= {dq_q[DVD_W-2:0], q_bit};
				rem_q  <= rem_nx;
				step_q <= step_q - STEP_W'(1);
			end
			bre_pkg::ST_MUL: begin
				unknown_q <= (dq_q[DVS_W-1:0] == '0);
				dvs_q     <= dq_q[DVS_W-1:0];
				dq_q      <= DVD_W'(prod) << (DVD_W - bre_pkg::PROD_W);
				rem_q     <= '0;
				step_q    <= STEP_W'(bre_pkg::PROD_W);
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == bre_pkg::ST_IDLE && in_accept &&
				in_data.op == bre_pkg::OP_READING) begin
			out_valid_q <= 1'b1;
		end else if (state_q == bre_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bre_pkg::ST_IDLE && in_accept && in_data.op == bre_pkg::OP_READING) begin
			out_q <= read_res;
		end else if (state_q == bre_pkg::ST_DONE && out_free) begin
			out_q.status       <= bre_pkg::STATUS_OK;
			out_q.state_out    <= cached_state_q;
			out_q.rate_out     <= cached_rate_q;
			out_q.capacity_out <= cached_cap_q;
			out_q.full_cap_out <= full_cap;
			out_q.secs_left    <= time_val;
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("ring fill count beyond depth");

	a_report_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_data.op == bre_pkg::OP_REPORT) |=> state_q == bre_pkg::ST_PUSH)
		else $error("report beat did not start a ring push");

	a_sum_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bre_pkg::ST_SUM |-> fill_q != '0)
		else $error("ring sum over an empty ring");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bre_pkg::ST_DIV_MEAN || state_q == bre_pkg::ST_DIV_TIME) |-> dvs_q != '0)
		else $error("divider running with a zero divisor");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == bre_pkg::STATUS_BAD) |->
			(out_q.secs_left == '0 && out_q.rate_out == '0))
		else $error("rejected reading carries report fields");

endmodule

// ===== bench/runtime_checker.sv =====
`timescale 1ns / 100ps

module runtime_checker #(
	parameter int RATE_DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  bre_pkg::in_item_t             in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  bre_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [bre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bre_pkg::DATA_W-1:0]    cfg_data,
	output int                            fail_count,
	output int                            outstanding,
	output int                            compared_count
);

	localparam int MAX_SHOWN = 10;

	// mirrored registers
	logic signed [bre_pkg::DATA_W-1:0] last_full;
	logic [bre_pkg::CAP_W-1:0]         design_cap;

	// mirrored rate history and reading cache
	logic signed [bre_pkg::DATA_W-1:0] rate_hist [RATE_DEPTH];
	int                                hist_slot;
	int                                hist_fill;
	logic [bre_pkg::STATE_W-1:0]       held_state;
	logic signed [bre_pkg::DATA_W-1:0] held_rate;
	logic [bre_pkg::CAP_W-1:0]         held_cap;

	// estimates waiting for their result beat, oldest first
	bre_pkg::out_item_t estimates_q [$];

	// reading: validate and cache; report: push rate, average, work out seconds left
	function automatic bre_pkg::out_item_t estimate_runtime(input bre_pkg::in_item_t item);
		bre_pkg::out_item_t res;
		longint             cap;
		longint             full;
		longint             rate_sum;
		longint             mean;
		longint             secs;
		int                 i;
		res = '0;
		if (item.op == bre_pkg::OP_READING) begin
			cap = $signed(item.capacity_in);
			if (cap < 0 || (last_full > 0 && cap > last_full)) begin
				res.status = bre_pkg::STATUS_BAD;
			end else begin
				held_state = item.battery_state;
				held_rate  = item.rate_in;
				held_cap   = item.capacity_in[bre_pkg::CAP_W-1:0];
			end
		end else begin
			// unknown last full charge falls back to the design value
			if (last_full < 0)
				full = design_cap;
			else
				full = last_full;

			rate_hist[hist_slot] = held_rate;
			hist_slot = (hist_slot == RATE_DEPTH - 1) ? 0 : hist_slot + 1;
			if (hist_fill < RATE_DEPTH)
				hist_fill++;

			// full-precision sum, mean truncated toward zero
			rate_sum = 0;
			for (i = 0; i < hist_fill; i++)
				rate_sum += rate_hist[i];
			mean = rate_sum / hist_fill;

			if (held_rate > 0 && mean != 0) begin
				secs = longint'(bre_pkg::SECS_PER_HOUR) * longint'(held_cap) / mean;
				if (secs > bre_pkg::INT32_MAX_C)
					secs = bre_pkg::INT32_MAX_C;
				if (secs < bre_pkg::INT32_MIN_C)
					secs = bre_pkg::INT32_MIN_C;
			end else begin
				secs = bre_pkg::TIME_UNKNOWN;
			end

			res.status       = bre_pkg::STATUS_OK;
			res.state_out    = held_state;
			res.rate_out     = held_rate;
			res.capacity_out = held_cap;
			res.full_cap_out = bre_pkg::DATA_W'(full);
			res.secs_left    = bre_pkg::DATA_W'(secs);
		end
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [bre_pkg::DATA_W-1:0] want,
			input logic [bre_pkg::DATA_W-1:0] got);
		if (want !== got) begin
			if (fail_count < MAX_SHOWN)
				$display("beat %0d: %s expected %h, got %h", compared_count, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_beat(input bre_pkg::out_item_t got);
		bre_pkg::out_item_t want;
		if (estimates_q.size() == 0) begin
			if (fail_count < MAX_SHOWN)
				$display("result beat %h arrived with no estimate pending", got);
			fail_count++;
		end else begin
			want = estimates_q.pop_front();
			compared_count++;
			compare_field("status", want.status, got.status);
			compare_field("state_out", want.state_out, got.state_out);
			compare_field("rate_out", want.rate_out, got.rate_out);
			compare_field("capacity_out", want.capacity_out, got.capacity_out);
			compare_field("full_cap_out", want.full_cap_out, got.full_cap_out);
			compare_field("secs_left", want.secs_left, got.secs_left);
		end
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_full  = bre_pkg::LFC_RESET;
			design_cap = '0;
			hist_slot  = 0;
			hist_fill  = 0;
			held_state = '0;
			held_rate  = '0;
			held_cap   = '0;
			estimates_q.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_beat(out_data);
			if (in_valid && !in_stall)
				estimates_q.push_back(estimate_runtime(in_data));
			if (cfg_we) begin
				case (cfg_index)
					bre_pkg::CFG_LAST_FULL: begin
						last_full = cfg_data;
					end
					bre_pkg::CFG_DESIGN_CAP: begin
						design_cap = cfg_data[bre_pkg::CAP_W-1:0];
					end
					default: begin
					end
				endcase
			end
			outstanding <= estimates_q.size();
		end
	end

endmodule

// ===== bench/tb_battery_runtime_estimator.sv =====
`timescale 1ns / 100ps

module tb_battery_runtime_estimator;

	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int DRAIN_CYCLES     = 120;
	localparam int BLOCKS_PER_PHASE = 10;
	localparam int ITEMS_PER_BLOCK  = 54;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	bre_pkg::in_item_t             in_data   = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	bre_pkg::out_item_t            out_data;
	logic                          cfg_we    = 1'b0;
	logic [bre_pkg::CFG_IDX_W-1:0] cfg_index = bre_pkg::CFG_LAST_FULL;
	logic [bre_pkg::DATA_W-1:0]    cfg_data  = '0;

	int fail_count;
	int outstanding;
	int compared_count;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int quiet_cycles  = 0;
	int item_total    = 0;
	int report_total  = 0;
	int setting_total = 0;

	logic signed [bre_pkg::DATA_W-1:0] lfc_setting = bre_pkg::LFC_RESET;

	battery_runtime_estimator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	runtime_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.compared_count (compared_count)
	);

	// clock
	always #5 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99, 0) < stall_pct);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// one input beat, with random idle cycles ahead of it
	task automatic send_beat(input bre_pkg::in_item_t item);
		if ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99, 0) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		item_total++;
		if (item.op == bre_pkg::OP_REPORT)
			report_total++;
	endtask

	// drop valid and wait until every estimate has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// write both registers on consecutive cycles
	task automatic configure(input logic [bre_pkg::DATA_W-1:0] lfc,
			input logic [bre_pkg::DATA_W-1:0] dc);
		cfg_we    <= 1'b1;
		cfg_index <= bre_pkg::CFG_LAST_FULL;
		cfg_data  <= lfc;
		@(posedge clk);
		cfg_index <= bre_pkg::CFG_DESIGN_CAP;
		cfg_data  <= dc;
		@(posedge clk);
		cfg_we <= 1'b0;
		lfc_setting = lfc;
		setting_total++;
	endtask

	function automatic bre_pkg::in_item_t reading_item(input logic [bre_pkg::STATE_W-1:0] st,
			input logic [bre_pkg::DATA_W-1:0] rate, input logic [bre_pkg::DATA_W-1:0] cap);
		bre_pkg::in_item_t item;
		item.op            = bre_pkg::OP_READING;
		item.battery_state = st;
		item.rate_in       = rate;
		item.capacity_in   = cap;
		return item;
	endfunction

	// payload of a report is ignored, so it carries noise
	function automatic bre_pkg::in_item_t report_item();
		bre_pkg::in_item_t item;
		item.op            = bre_pkg::OP_REPORT;
		item.battery_state = $urandom;
		item.rate_in       = $urandom;
		item.capacity_in   = $urandom;
		return item;
	endfunction

	// mostly plausible readings, some rejected ones, reports in between
	function automatic bre_pkg::in_item_t random_item();
		bre_pkg::in_item_t item;
		int                pick;
		if ($urandom_range(99, 0) < 45) begin
			item = report_item();
		end else begin
			item.op            = bre_pkg::OP_READING;
			item.battery_state = $urandom;
			pick = $urandom_range(99, 0);
			if (pick < 65)
				item.rate_in = $urandom_range(5000, 1);
			else if (pick < 75)
				item.rate_in = '0;
			else if (pick < 87)
				item.rate_in = -$urandom_range(5000, 1);
			else if (pick < 95)
				item.rate_in = $urandom;
			else
				item.rate_in = $urandom_range(1, 0) ? bre_pkg::INT32_MAX_C : bre_pkg::INT32_MIN_C;
			pick = $urandom_range(99, 0);
			if (pick < 12)
				item.capacity_in = $urandom | 32'h8000_0000;
			else if (pick < 22 && lfc_setting > 0 && lfc_setting != bre_pkg::INT32_MAX_C)
				item.capacity_in = $urandom_range(bre_pkg::INT32_MAX_C, lfc_setting + 1);
			else if (lfc_setting > 0)
				item.capacity_in = $urandom_range(lfc_setting, 0);
			else if (pick < 60)
				item.capacity_in = $urandom_range(100000, 0);
			else
				item.capacity_in = $urandom >> 1;
		end
		return item;
	endfunction

	// stimulus and verdict
	initial begin
		int phase;
		int blk;
		logic [bre_pkg::DATA_W-1:0] lfc;
		logic [bre_pkg::DATA_W-1:0] dc;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 12;
		stall_pct    <= 51;

		// report before any reading, registers at reset values
		send_beat(report_item());

		wait_idle();
		configure(32'd1000, 32'h7fff_ffff);
		// negative capacity and capacity above last full charge are rejected
		send_beat(reading_item(8'hff, 32'd50, 32'hffff_ffff));
		send_beat(reading_item(8'h00, 32'd50, 32'd1001));
		// capacity exactly at the limit
		send_beat(reading_item(8'hff, 32'd50, 32'd1000));
		send_beat(report_item());
		// empty battery
		send_beat(reading_item(8'h5a, 32'd1, 32'd0));
		send_beat(report_item());
		// charging and idle rates leave the time unknown
		send_beat(reading_item(8'ha5, -32'sd5, 32'd500));
		send_beat(report_item());
		send_beat(reading_item(8'h01, 32'd0, 32'd500));
		send_beat(report_item());

		wait_idle();
		configure(32'd0, 32'd0);
		// no upper bound; huge time saturates
		send_beat(reading_item(8'h80, 32'd1, bre_pkg::INT32_MAX_C));
		send_beat(report_item());
		send_beat(reading_item(8'h7f, bre_pkg::INT32_MIN_C, bre_pkg::INT32_MAX_C));
		send_beat(report_item());
		// history mean dragged negative
		send_beat(reading_item(8'h3c, 32'd1, 32'd12345));
		send_beat(report_item());

		wait_idle();
		configure(bre_pkg::INT32_MIN_C, 32'hffff_ffff);
		send_beat(report_item());

		wait_idle();
		configure(bre_pkg::INT32_MAX_C, 32'd0);
		// extreme rates cancel out and the mean truncates to zero
		send_beat(reading_item(8'hc3, bre_pkg::INT32_MAX_C, bre_pkg::INT32_MAX_C));
		send_beat(report_item());
		send_beat(reading_item(8'h00, 32'd1, bre_pkg::INT32_MIN_C));
		send_beat(report_item());

		// random traffic under three pacing profiles
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 12;
					stall_pct    <= 51;
				end
				1: begin
					send_idle_pct = 51;
					stall_pct    <= 12;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct    <= 0;
				end
			endcase
			for (blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
				wait_idle();
				case ($urandom_range(6, 0))
					0: lfc = bre_pkg::LFC_RESET;
					1: lfc = '0;
					2: lfc = 32'd1;
					3: lfc = bre_pkg::INT32_MAX_C;
					4: lfc = $urandom_range(100000, 1);
					5: lfc = $urandom >> 1;
					default: lfc = $urandom | 32'h8000_0000;
				endcase
				case ($urandom_range(2, 0))
					0: dc = '0;
					1: dc = '1;
					default: dc = $urandom;
				endcase
				configure(lfc, dc);
				repeat (ITEMS_PER_BLOCK)
					send_beat(random_item());
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items, %0d of them reports, under %0d register settings",
			item_total, report_total, setting_total);
		$display("compared %0d result beats, %0d mismatches", compared_count, fail_count);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/bre_pkg.sv
src/bre_ram.sv
src/battery_runtime_estimator.sv
bench/runtime_checker.sv
bench/tb_battery_runtime_estimator.sv
